/* hdl/jcrc_pkg.sv */
// Shared types, constants and a helper function for the joystick calibrator.
`default_nettype none
package jcrc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int DIV_CNT_W   = $clog2(SUM_BITS);
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 104;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_BITS - 1);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_INACTIVE  = 2'd0,
    PH_CENTERING = 2'd1,
    PH_CAPTURING = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_WINDOW   = 3'd0,
    REG_TIMEOUT  = 3'd1,
    REG_TRAVEL   = 3'd2,
    REG_MARGIN   = 3'd3,
    REG_FLOOR    = 3'd4,
    REG_CEILING  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SAMP, S_DIV, S_CENT, S_BOUND, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_START, CMD_TOUCH, CMD_CANCEL, CMD_ACCUM,
    CMD_DIV_INIT, CMD_DIV_STEP, CMD_CENTER, CMD_BOUND, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    op_t    op;
    phase_t phase;
    logic   elapsed;
    logic   count_nz;
    logic   div_last;
    logic   out_free;
  } dp_status_t;

  // Jitter plus margin, clamped to floor first and then to ceiling.
  function automatic logic [SAMPLE_BITS-1:0] deadzone(
    input logic [SAMPLE_BITS-1:0] c,
    input logic [SAMPLE_BITS-1:0] lo,
    input logic [SAMPLE_BITS-1:0] hi,
    input logic [SAMPLE_BITS-1:0] margin,
    input logic [SAMPLE_BITS-1:0] flr,
    input logic [SAMPLE_BITS-1:0] ceil);
    logic [SAMPLE_BITS-1:0] j1;
    logic [SAMPLE_BITS-1:0] j2;
    logic [SAMPLE_BITS-1:0] jm;
    logic [SAMPLE_BITS:0]   v;
    logic [SAMPLE_BITS-1:0] res;
    j1 = (c > lo) ? c - lo : lo - c;
    j2 = (hi > c) ? hi - c : c - hi;
    jm = (j1 > j2) ? j1 : j2;
    v  = {1'b0, jm} + {1'b0, margin};
    if (v < {1'b0, flr}) begin
      res = flr;
    end else if (v > {1'b0, ceil}) begin
      res = ceil;
    end else begin
      res = v[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hdl/jcrc_ctrl.sv */
// Controller state machine sequencing one item through the datapath.
`default_nettype none
module jcrc_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  jcrc_pkg::dp_status_t   sts,
  output jcrc_pkg::cmd_t         cmd
);
  import jcrc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (sts.op)
          OP_START, OP_SAMPLE: state_nxt = S_SAMP;
          default:             state_nxt = S_OUT;
        endcase
      end
      S_SAMP: begin
        case (sts.phase)
          PH_CENTERING: begin
            if (!sts.elapsed)      state_nxt = S_OUT;
            else if (sts.count_nz) state_nxt = S_DIV;
            else                   state_nxt = S_BOUND;
          end
          PH_CAPTURING: state_nxt = S_BOUND;
          default:      state_nxt = S_OUT;
        endcase
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_CENT;
      end
      S_CENT:  state_nxt = S_BOUND;
      S_BOUND: state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd       = CMD_NONE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd = CMD_LOAD;
      end
      S_EXEC: begin
        case (sts.op)
          OP_START:  cmd = CMD_START;
          OP_TOUCH:  cmd = CMD_TOUCH;
          OP_CANCEL: cmd = CMD_CANCEL;
          default:   cmd = CMD_NONE;
        endcase
      end
      S_SAMP: begin
        if (sts.phase == PH_CENTERING) begin
          if (!sts.elapsed)      cmd = CMD_ACCUM;
          else if (sts.count_nz) cmd = CMD_DIV_INIT;
        end
      end
      S_DIV:   cmd = CMD_DIV_STEP;
      S_CENT:  cmd = CMD_CENTER;
      S_BOUND: cmd = CMD_BOUND;
      S_OUT: begin
        if (sts.out_free) cmd = CMD_EMIT;
      end
      default: cmd = CMD_NONE;
    endcase
  end

  // An accepted beat always goes to the operation step next
  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted beat did not enter operation step");

  // The last divide step is followed by the center update
  a_div_cent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_CENT))
    else $error("divide did not finish into center update");

  // Emitting a result returns to idle
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_EMIT) |=> (state_r == S_IDLE))
    else $error("result emit did not return to idle");

endmodule
`default_nettype wire

/* hdl/jcrc_dp.sv */
// Datapath: session state, config registers, divider and result register.
`default_nettype none
module jcrc_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  jcrc_pkg::cmd_t                       cmd,
  output jcrc_pkg::dp_status_t                 sts,
  input  wire  [1:0]                           in_op,
  input  wire  [31:0]                          in_now,
  input  wire  [jcrc_pkg::SAMPLE_BITS-1:0]     in_x,
  input  wire  [jcrc_pkg::SAMPLE_BITS-1:0]     in_y,
  input  wire                                  cfg_we,
  input  wire  [jcrc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire  [jcrc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [jcrc_pkg::OUT_DATA_W-1:0]      out_data
);
  import jcrc_pkg::*;

  localparam int SB = SAMPLE_BITS;

  // Config registers
  logic [15:0]   win_r;
  logic [31:0]   tmo_r;
  logic [SB-1:0] trav_r, marg_r, flr_r, ceil_r;

  // Latched item
  op_t           op_r;
  logic [31:0]   now_r;
  logic [SB-1:0] x_r, y_r;

  // Session state
  phase_t                phase_r;
  logic [31:0]           start_r, act_r;
  logic [SUM_BITS-1:0]   sumx_r, sumy_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [SB-1:0]         smnx_r, smxx_r, smny_r, smxy_r;
  logic [SB-1:0]         cx_r, cy_r;
  logic [SB-1:0]         lox_r, hix_r, loy_r, hiy_r;
  logic                  sess_go;

  // Divider
  logic [SUM_BITS-1:0]   qx_r, qy_r;
  logic [COUNT_BITS-1:0] rx_r, ry_r;
  logic [DIV_CNT_W-1:0]  dcnt_r;
  logic [COUNT_BITS:0]   rxs, rys;
  logic                  gex, gey;

  // Result register
  logic                  ovalid_r;
  logic [OUT_DATA_W-1:0] odata_r;
  logic [OUT_DATA_W-1:0] res;

  logic [31:0] elapsed_ms, idle_ms;
  logic        timed;
  logic [SB-1:0] dzx, dzy;
  logic        tok;

  assign elapsed_ms = now_r - start_r;
  assign idle_ms    = now_r - act_r;
  assign sess_go    = rst_n && (cmd == CMD_START);

  assign sts.op       = op_r;
  assign sts.phase    = phase_r;
  assign sts.elapsed  = (elapsed_ms >= {16'd0, win_r});
  assign sts.count_nz = (cnt_r != '0);
  assign sts.div_last = (dcnt_r == DIV_LAST);
  assign sts.out_free = !ovalid_r || out_ready;

  // Divider trial subtraction, both axes in parallel
  assign rxs = {rx_r, qx_r[SUM_BITS-1]};
  assign rys = {ry_r, qy_r[SUM_BITS-1]};
  assign gex = (rxs >= {1'b0, cnt_r});
  assign gey = (rys >= {1'b0, cnt_r});

  // Write config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= 16'd1000;
      tmo_r  <= 32'd30000;
      trav_r <= SB'(200);
      marg_r <= SB'(16);
      flr_r  <= '0;
      ceil_r <= SB'(512);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_WINDOW:  win_r  <= cfg_wdata[15:0];
        REG_TIMEOUT: tmo_r  <= cfg_wdata;
        REG_TRAVEL:  trav_r <= cfg_wdata[SB-1:0];
        REG_MARGIN:  marg_r <= cfg_wdata[SB-1:0];
        REG_FLOOR:   flr_r  <= cfg_wdata[SB-1:0];
        REG_CEILING: ceil_r <= cfg_wdata[SB-1:0];
        default: ;
      endcase
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      op_r  <= op_t'(in_op);
      now_r <= in_now;
      x_r   <= in_x;
      y_r   <= in_y;
    end
  end

  // Update session state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd == CMD_CANCEL || cmd == CMD_START) begin
      phase_r <= sess_go ? PH_CENTERING : PH_INACTIVE;
      start_r <= sess_go ? now_r : '0;
      act_r   <= sess_go ? now_r : '0;
      sumx_r  <= '0;
      sumy_r  <= '0;
      cnt_r   <= '0;
      smnx_r  <= SAMPLE_MAX;
      smxx_r  <= '0;
      smny_r  <= SAMPLE_MAX;
      smxy_r  <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      lox_r   <= '0;
      hix_r   <= '0;
      loy_r   <= '0;
      hiy_r   <= '0;
    end else begin
      case (cmd)
        CMD_TOUCH: begin
          if (phase_r != PH_INACTIVE) act_r <= now_r;
        end
        CMD_ACCUM: begin
          if (cnt_r != COUNT_MAX) begin
            sumx_r <= sumx_r + SUM_BITS'(x_r);
            sumy_r <= sumy_r + SUM_BITS'(y_r);
            cnt_r  <= cnt_r + 1'b1;
          end
          if (x_r < smnx_r) smnx_r <= x_r;
          if (x_r > smxx_r) smxx_r <= x_r;
          if (y_r < smny_r) smny_r <= y_r;
          if (y_r > smxy_r) smxy_r <= y_r;
        end
        CMD_CENTER: begin
          cx_r    <= qx_r[SB-1:0];
          cy_r    <= qy_r[SB-1:0];
          lox_r   <= qx_r[SB-1:0];
          hix_r   <= qx_r[SB-1:0];
          loy_r   <= qy_r[SB-1:0];
          hiy_r   <= qy_r[SB-1:0];
          phase_r <= PH_CAPTURING;
        end
        CMD_BOUND: begin
          if (x_r < lox_r) lox_r <= x_r;
          if (x_r > hix_r) hix_r <= x_r;
          if (y_r < loy_r) loy_r <= y_r;
          if (y_r > hiy_r) hiy_r <= y_r;
        end
        default: ;
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd == CMD_DIV_INIT) begin
      qx_r   <= sumx_r;
      qy_r   <= sumy_r;
      rx_r   <= '0;
      ry_r   <= '0;
      dcnt_r <= '0;
    end else if (cmd == CMD_DIV_STEP) begin
      rx_r   <= gex ? COUNT_BITS'(rxs - {1'b0, cnt_r}) : rxs[COUNT_BITS-1:0];
      ry_r   <= gey ? COUNT_BITS'(rys - {1'b0, cnt_r}) : rys[COUNT_BITS-1:0];
      qx_r   <= {qx_r[SUM_BITS-2:0], gex};
      qy_r   <= {qy_r[SUM_BITS-2:0], gey};
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // Form the result
  assign timed = (phase_r != PH_INACTIVE) && (idle_ms >= tmo_r);
  assign tok   = ((cx_r - lox_r) >= trav_r) && ((hix_r - cx_r) >= trav_r) &&
                 ((cy_r - loy_r) >= trav_r) && ((hiy_r - cy_r) >= trav_r);
  assign dzx   = deadzone(cx_r, smnx_r, smxx_r, marg_r, flr_r, ceil_r);
  assign dzy   = deadzone(cy_r, smny_r, smxy_r, marg_r, flr_r, ceil_r);

  always_comb begin
    res       = '0;
    res[1:0]  = phase_r;
    res[2]    = timed;
    if (phase_r == PH_CAPTURING) begin
      res[3]      = 1'b1;
      res[4]      = tok;
      res[16:5]   = lox_r;
      res[28:17]  = cx_r;
      res[40:29]  = hix_r;
      res[52:41]  = loy_r;
      res[64:53]  = cy_r;
      res[76:65]  = hiy_r;
      res[88:77]  = dzx;
      res[100:89] = dzy;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) odata_r <= res;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule
`default_nettype wire

/* hdl/joystick_center_range_calibrator_top.sv */
// Top level of the two-axis joystick center and range calibrator.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_tvalid / in_tready  | in_tuser op, in_tdata now/x/y
//  out_    | output    | out_tvalid / out_tready| out_tdata mode..dead_y
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item at a time: each passes the operation and output steps; start and
// samples also the sample step, a capturing sample the bound step, and
// a window-closing sample the restoring divider (both axes in parallel) and
// center update; the output step waits for the result register to drain.
// Reset (rst_n low, synchronous) returns config to defaults and the session
// to inactive. in_tready is low while an item is in work; a stalled result
// holds in the output register. Config is always ready.
`default_nettype none
module joystick_center_range_calibrator_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [1:0]                          in_tuser,   // op
  input  wire  [jcrc_pkg::IN_DATA_W-1:0]      in_tdata,   // now_ms, sample_x, sample_y
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // mode, timed_out, result_available, travel_ok, low_x, mid_x, high_x,
  // low_y, mid_y, high_y, dead_x, dead_y, zero pad
  output logic [jcrc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [jcrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [jcrc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import jcrc_pkg::*;

  cmd_t       cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  jcrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jcrc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_tuser),
    .in_now    (in_tdata[31:0]),
    .in_x      (in_tdata[43:32]),
    .in_y      (in_tdata[55:44]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the joystick center and range calibrator.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jcrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1600;

  typedef struct packed {
    logic [11:0] dead_y, dead_x, high_y, mid_y, low_y, high_x, mid_x, low_x;
    logic        travel_ok, result_available, timed_out;
    logic [1:0]  mode;
  } calib_t;

  typedef struct {
    op_t         op;
    logic [31:0] now;
    logic [11:0] x, y;
    logic        typed;
    calib_t      res;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  joystick_center_range_calibrator_top i_dut (.*);

  // predictor state and registers
  logic [15:0] win_ms;
  logic [31:0] tmo_ms;
  logic [11:0] travel_min, dz_margin, dz_floor, dz_ceil;
  phase_t      ph;
  logic [31:0] t_start, t_act;
  logic [27:0] acc_x, acc_y;
  logic [15:0] n_samp;
  logic [11:0] jmin_x, jmax_x, jmin_y, jmax_y, ctr_x, ctr_y;
  logic [11:0] lo_x, hi_x, lo_y, hi_y;

  calib_t expected_q[$];
  int     errors = 0;
  bit     quiet = 0;
  int     idle_cnt = 0;

  function automatic void clear_session();
    ph = PH_INACTIVE; t_start = 0; t_act = 0; acc_x = 0; acc_y = 0; n_samp = 0;
    jmin_x = '1; jmax_x = 0; jmin_y = '1; jmax_y = 0;
    ctr_x = 0; ctr_y = 0; lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
  endfunction

  task automatic reset_regs();
    win_ms = 1000; tmo_ms = 30000; travel_min = 200;
    dz_margin = 16; dz_floor = 0; dz_ceil = 512;
  endtask

  function automatic logic [11:0] clamp_dz(logic [11:0] c, logic [11:0] lo, logic [11:0] hi);
    logic [12:0] j1, j2, v;
    j1 = (c > lo) ? c - lo : lo - c;
    j2 = (hi > c) ? hi - c : c - hi;
    v = ((j1 > j2) ? j1 : j2) + dz_margin;
    if (v < dz_floor) return dz_floor;
    if (v > dz_ceil) return dz_ceil;
    return v[11:0];
  endfunction

  // advance the calibration state by one sample
  function automatic void absorb_sample(logic [31:0] now, logic [11:0] x, logic [11:0] y);
    logic [31:0] el;
    el = now - t_start;
    if (ph == PH_INACTIVE) return;
    if (ph == PH_CENTERING) begin
      if (el >= {16'd0, win_ms}) begin
        if (n_samp != 0) begin
          ctr_x = 12'(acc_x / n_samp); ctr_y = 12'(acc_y / n_samp);
          lo_x = ctr_x; hi_x = ctr_x; lo_y = ctr_y; hi_y = ctr_y;
          ph = PH_CAPTURING;
        end
      end else begin
        if (n_samp != COUNT_MAX) begin
          acc_x += x; acc_y += y; n_samp++;
        end
        if (x < jmin_x) jmin_x = x;
        if (x > jmax_x) jmax_x = x;
        if (y < jmin_y) jmin_y = y;
        if (y > jmax_y) jmax_y = y;
        return;
      end
    end
    if (x < lo_x) lo_x = x;
    if (x > hi_x) hi_x = x;
    if (y < lo_y) lo_y = y;
    if (y > hi_y) hi_y = y;
  endfunction

  function automatic calib_t predict_calib(op_t op, logic [31:0] now,
                                           logic [11:0] x, logic [11:0] y);
    calib_t r;
    case (op)
      OP_START: begin
        clear_session(); ph = PH_CENTERING; t_start = now; t_act = now;
        absorb_sample(now, x, y);
      end
      OP_SAMPLE: absorb_sample(now, x, y);
      OP_TOUCH: if (ph != PH_INACTIVE) t_act = now;
      default: clear_session();
    endcase
    r = '0;
    r.mode = ph;
    r.timed_out = (ph != PH_INACTIVE) && ((now - t_act) >= tmo_ms);
    if (ph == PH_CAPTURING) begin
      r.result_available = 1'b1;
      r.travel_ok = (ctr_x - lo_x >= travel_min) && (hi_x - ctr_x >= travel_min) &&
                    (ctr_y - lo_y >= travel_min) && (hi_y - ctr_y >= travel_min);
      r.low_x = lo_x; r.mid_x = ctr_x; r.high_x = hi_x;
      r.low_y = lo_y; r.mid_y = ctr_y; r.high_y = hi_y;
      r.dead_x = clamp_dz(ctr_x, jmin_x, jmax_x);
      r.dead_y = clamp_dz(ctr_y, jmin_y, jmax_y);
    end
    return r;
  endfunction

  // drive one beat; the expected result is queued at acceptance
  task automatic send_item(op_t op, logic [31:0] now, logic [11:0] x, logic [11:0] y,
                           bit typed = 0, calib_t want = '0);
    calib_t p;
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
    in_tvalid = 1'b1; in_tuser = op; in_tdata = {y, x, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_calib(op, now, x, y);
    if (typed && p !== want) begin
      $error("table row: predictor %h, typed %h", p, want);
      errors++;
    end
    expected_q.push_back(p);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WINDOW: win_ms = val[15:0];
      REG_TIMEOUT: tmo_ms = val;
      REG_TRAVEL: travel_min = val[11:0];
      REG_MARGIN: dz_margin = val[11:0];
      REG_FLOOR: dz_floor = val[11:0];
      default: dz_ceil = val[11:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    calib_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(calib_t)-1:0];
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.mode !== exp_r.mode) begin
          $error("mode exp %0d got %0d", exp_r.mode, got.mode); errors++; end
        if (got.timed_out !== exp_r.timed_out) begin
          $error("timed_out exp %0d got %0d", exp_r.timed_out, got.timed_out); errors++; end
        if (got.result_available !== exp_r.result_available) begin
          $error("result_available exp %0d got %0d", exp_r.result_available,
                 got.result_available); errors++; end
        if (got.travel_ok !== exp_r.travel_ok) begin
          $error("travel_ok exp %0d got %0d", exp_r.travel_ok, got.travel_ok); errors++; end
        if (got.low_x !== exp_r.low_x) begin
          $error("low_x exp %0d got %0d", exp_r.low_x, got.low_x); errors++; end
        if (got.mid_x !== exp_r.mid_x) begin
          $error("mid_x exp %0d got %0d", exp_r.mid_x, got.mid_x); errors++; end
        if (got.high_x !== exp_r.high_x) begin
          $error("high_x exp %0d got %0d", exp_r.high_x, got.high_x); errors++; end
        if (got.low_y !== exp_r.low_y) begin
          $error("low_y exp %0d got %0d", exp_r.low_y, got.low_y); errors++; end
        if (got.mid_y !== exp_r.mid_y) begin
          $error("mid_y exp %0d got %0d", exp_r.mid_y, got.mid_y); errors++; end
        if (got.high_y !== exp_r.high_y) begin
          $error("high_y exp %0d got %0d", exp_r.high_y, got.high_y); errors++; end
        if (got.dead_x !== exp_r.dead_x) begin
          $error("dead_x exp %0d got %0d", exp_r.dead_x, got.dead_x); errors++; end
        if (got.dead_y !== exp_r.dead_y) begin
          $error("dead_y exp %0d got %0d", exp_r.dead_y, got.dead_y); errors++; end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("** joystick_center_range_calibrator_top: FAILED **");
      $finish;
    end
  end

  // one random session, mostly well formed
  task automatic random_session(inout logic [31:0] now, inout int sent);
    logic [11:0] cx, cy;
    int k, n;
    cx = 12'($urandom_range(0, 4095)); cy = 12'($urandom_range(0, 4095));
    send_item(OP_START, now, cx, cy); sent++;
    n = $urandom_range(2, 12);
    for (k = 0; k < n; k++) begin
      now += $urandom_range(0, (win_ms / 4) + 1);
      send_item(OP_SAMPLE, now, cx ^ 12'($urandom_range(0, 15)),
                cy ^ 12'($urandom_range(0, 15))); sent++;
    end
    now += win_ms;
    n = $urandom_range(3, 20);
    for (k = 0; k < n; k++) begin
      now += $urandom_range(0, 3000);
      case ($urandom_range(0, 9))
        0: send_item(OP_TOUCH, now, 12'($urandom), 12'($urandom));
        1: send_item(op_t'($urandom_range(0, 3)), $urandom, 12'($urandom), 12'($urandom));
        default: send_item(OP_SAMPLE, now, 12'($urandom), 12'($urandom));
      endcase
      sent++;
    end
    if ($urandom_range(0, 3) == 0) begin
      send_item(OP_CANCEL, now, 12'($urandom), 12'($urandom)); sent++;
    end
  endtask

  initial begin
    vec_t tbl[$];
    vec_t v;
    calib_t z;
    logic [31:0] now;
    int sent;
    reset_regs(); clear_session();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table; typed results only where obvious
    z = '0;
    tbl.push_back('{OP_SAMPLE, 32'd5, 12'hFFF, 12'hFFF, 1, z});
    tbl.push_back('{OP_TOUCH, 32'd6, 12'h000, 12'h000, 1, z});
    tbl.push_back('{OP_CANCEL, 32'hFFFF_FFFF, 12'hFFF, 12'h000, 1, z});
    z.mode = PH_CENTERING;
    tbl.push_back('{OP_START, 32'hFFFF_FF00, 12'h000, 12'hFFF, 1, z});
    tbl.push_back('{OP_SAMPLE, 32'hFFFF_FF10, 12'hFFF, 12'h000, 1, z});
    tbl.push_back('{OP_SAMPLE, 32'h0000_0300, 12'h800, 12'h7FF, 0, z});
    tbl.push_back('{OP_SAMPLE, 32'h0000_0310, 12'h000, 12'hFFF, 0, z});
    tbl.push_back('{OP_TOUCH, 32'h0000_0400, 12'h000, 12'h000, 0, z});
    tbl.push_back('{OP_SAMPLE, 32'h0000_8000, 12'h555, 12'hAAA, 0, z});
    z.timed_out = 1'b1;
    z.mode = PH_INACTIVE; z.timed_out = 0;
    tbl.push_back('{OP_CANCEL, 32'h0000_9000, 12'h000, 12'h000, 1, z});
    foreach (tbl[i]) begin
      v = tbl[i];
      send_item(v.op, v.now, v.x, v.y, v.typed, v.res);
    end
    drain();

    // extreme settings: zero window, zero timeout, floor above ceiling
    write_reg(REG_WINDOW, 0); write_reg(REG_TIMEOUT, 0); write_reg(REG_TRAVEL, 0);
    write_reg(REG_MARGIN, 4095); write_reg(REG_FLOOR, 4095); write_reg(REG_CEILING, 0);
    send_item(OP_START, 100, 12'hFFF, 12'h000);
    send_item(OP_SAMPLE, 100, 12'h123, 12'h456);
    send_item(OP_TOUCH, 200, 0, 0);
    send_item(OP_CANCEL, 200, 0, 0);
    drain();

    // longest window, closed by a late sample
    write_reg(REG_WINDOW, 65535); write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_FLOOR, 10); write_reg(REG_CEILING, 300); write_reg(REG_MARGIN, 0);
    write_reg(REG_TRAVEL, 4095);
    quiet = 1;
    send_item(OP_START, 0, 12'hFFF, 12'hFFF);
    for (int k = 0; k < 40; k++) send_item(OP_SAMPLE, 1, 12'hFFF, 12'hFFE);
    send_item(OP_SAMPLE, 65535, 0, 4095);
    quiet = 0;
    drain();

    // random phases under several settings
    now = $urandom;
    sent = 0;
    for (int ph_i = 0; ph_i < 4; ph_i++) begin
      write_reg(REG_WINDOW, $urandom_range(1, 2000));
      write_reg(REG_TIMEOUT, $urandom_range(1, 20000));
      write_reg(REG_TRAVEL, $urandom_range(0, 600));
      write_reg(REG_MARGIN, $urandom_range(0, 4095));
      write_reg(REG_FLOOR, $urandom_range(0, 4095));
      write_reg(REG_CEILING, $urandom_range(0, 4095));
      if (ph_i == 3) quiet = 1;
      while (sent < (ph_i + 1) * (N_RANDOM / 4)) random_session(now, sent);
      drain();
    end

    if (errors == 0) begin
      $display("** joystick_center_range_calibrator_top: PASSED **");
    end else begin
      $display("** joystick_center_range_calibrator_top: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hdl/jcrc_pkg.sv
hdl/jcrc_ctrl.sv
hdl/jcrc_dp.sv
hdl/joystick_center_range_calibrator_top.sv
sim/tb_top.sv
